>>> hdl/srri_pkg.sv
// ----------------------------------------------------------------------------
// srri_pkg
// Shared widths, constants and types of the segment/rectangle hit tester.
// ----------------------------------------------------------------------------
package srri_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int PW         = COORD_BITS + 2;
  localparam int DW         = PW + 1;
  localparam int MW         = 2 * DW;
  localparam int XW         = MW + 1;
  localparam int CW         = XW + 1;

  localparam longint ONE_VAL   = longint'(1) << FRAC_BITS;
  localparam longint CLAMP_VAL = (101 * ONE_VAL + 50) / 100;
  localparam longint PAR_VAL   = ((longint'(1) << (2 * FRAC_BITS + 2)) + 999999) / 1000000;

  localparam logic [SIZE_BITS-1:0]         SIZE_ONE   = SIZE_BITS'(ONE_VAL);
  localparam logic [SIZE_BITS-1:0]         SIZE_CLAMP = SIZE_BITS'(CLAMP_VAL);
  localparam logic signed [COORD_BITS-1:0] COORD_ONE  = COORD_BITS'(ONE_VAL);
  localparam logic signed [XW-1:0]         PAR_THR    = XW'(PAR_VAL);

  localparam logic ACT_SEG  = 1'b0;
  localparam logic ACT_RECT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] srri_coord_t;
  typedef logic [SIZE_BITS-1:0]         srri_size_t;
  typedef logic signed [PW-1:0]         srri_pt_t;

  typedef struct packed {
    srri_pt_t l;
    srri_pt_t r;
    srri_pt_t t;
    srri_pt_t d;
    srri_pt_t x1;
    srri_pt_t y1;
    srri_pt_t x2;
    srri_pt_t y2;
    logic     first;
    logic     last;
  } srri_op_t;

  typedef struct packed {
    logic hit;
    logic first;
    logic last;
  } srri_res_t;

endpackage

>>> hdl/srri_if.sv
// ----------------------------------------------------------------------------
// srri_in_if / srri_out_if
// Valid/ready request and result channels of the hit tester.
// ----------------------------------------------------------------------------
interface srri_in_if;
  import srri_pkg::*;
  logic        valid;
  logic        ready;
  logic        action;
  srri_coord_t a_center_x;
  srri_coord_t a_center_y;
  srri_size_t  a_width;
  srri_size_t  a_height;
  srri_coord_t first_x;
  srri_coord_t first_y;
  srri_coord_t second_x;
  srri_coord_t second_y;

  modport source (output valid, action, a_center_x, a_center_y, a_width, a_height,
                  first_x, first_y, second_x, second_y, input ready);
  modport sink (input valid, action, a_center_x, a_center_y, a_width, a_height,
                first_x, first_y, second_x, second_y, output ready);
endinterface

interface srri_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> hdl/srri_issue.sv
// ----------------------------------------------------------------------------
// srri_issue
// Input register; passes a segment request on as its own op, splits a rectangle into edge ops.
// ----------------------------------------------------------------------------
module srri_issue import srri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  srri_in_if.sink  in_chan,
  output srri_op_t op,
  output logic     op_valid,
  input  logic     op_ready
);

  logic       v_r, mode_r;
  logic [1:0] k_r;
  srri_pt_t   l_r, r_r, t_r, d_r, px0_r, px1_r, py0_r, py1_r;

  logic        last_op, fire, accept;
  srri_size_t  aw_eff, ah_eff;
  srri_coord_t bw, bh;
  srri_pt_t    ax2, ay2, awx, ahx, fx2, fy2, gx2, gy2, bwx, bhx;
  srri_pt_t    l_nxt, r_nxt, t_nxt, d_nxt, px0_nxt, px1_nxt, py0_nxt, py1_nxt;

  assign last_op        = (mode_r == ACT_SEG) || (k_r == 2'd3);
  assign fire           = v_r && op_ready;
  assign in_chan.ready  = !v_r || (fire && last_op);
  assign accept         = in_chan.valid && in_chan.ready;
  assign op_valid       = v_r;

  always_comb begin
    aw_eff = in_chan.a_width;
    ah_eff = in_chan.a_height;
    bw     = in_chan.second_x;
    bh     = in_chan.second_y;
    if (in_chan.action == ACT_RECT) begin
      if (in_chan.a_width < SIZE_ONE) aw_eff = SIZE_CLAMP;
      if (in_chan.a_height < SIZE_ONE) ah_eff = SIZE_CLAMP;
      if (in_chan.second_x < COORD_ONE) bw = {1'b0, SIZE_CLAMP};
      if (in_chan.second_y < COORD_ONE) bh = {1'b0, SIZE_CLAMP};
    end
    ax2 = {in_chan.a_center_x[COORD_BITS-1], in_chan.a_center_x, 1'b0};
    ay2 = {in_chan.a_center_y[COORD_BITS-1], in_chan.a_center_y, 1'b0};
    fx2 = {in_chan.first_x[COORD_BITS-1], in_chan.first_x, 1'b0};
    fy2 = {in_chan.first_y[COORD_BITS-1], in_chan.first_y, 1'b0};
    gx2 = {in_chan.second_x[COORD_BITS-1], in_chan.second_x, 1'b0};
    gy2 = {in_chan.second_y[COORD_BITS-1], in_chan.second_y, 1'b0};
    awx = {{(PW-SIZE_BITS){1'b0}}, aw_eff};
    ahx = {{(PW-SIZE_BITS){1'b0}}, ah_eff};
    bwx = {{(PW-COORD_BITS){bw[COORD_BITS-1]}}, bw};
    bhx = {{(PW-COORD_BITS){bh[COORD_BITS-1]}}, bh};
    l_nxt = ax2 - awx;
    r_nxt = ax2 + awx;
    t_nxt = ay2 - ahx;
    d_nxt = ay2 + ahx;
    if (in_chan.action == ACT_RECT) begin
      px0_nxt = fx2 - bwx;
      px1_nxt = fx2 + bwx;
      py0_nxt = fy2 - bhx;
      py1_nxt = fy2 + bhx;
    end else begin
      px0_nxt = fx2;
      px1_nxt = gx2;
      py0_nxt = fy2;
      py1_nxt = gy2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      k_r <= 2'd0;
    end else if (accept) begin
      v_r <= 1'b1;
      k_r <= 2'd0;
    end else if (fire) begin
      if (last_op) v_r <= 1'b0;
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_chan.action;
      l_r    <= l_nxt;
      r_r    <= r_nxt;
      t_r    <= t_nxt;
      d_r    <= d_nxt;
      px0_r  <= px0_nxt;
      px1_r  <= px1_nxt;
      py0_r  <= py0_nxt;
      py1_r  <= py1_nxt;
    end
  end

  always_comb begin
    op.l     = l_r;
    op.r     = r_r;
    op.t     = t_r;
    op.d     = d_r;
    op.first = (k_r == 2'd0);
    op.last  = last_op;
    op.x1    = px0_r;
    op.y1    = py0_r;
    op.x2    = px1_r;
    op.y2    = py1_r;
    if (mode_r == ACT_RECT) begin
      unique case (k_r)
        2'd0: begin
          op.x1 = px0_r; op.y1 = py0_r; op.x2 = px1_r; op.y2 = py0_r;
        end
        2'd1: begin
          op.x1 = px1_r; op.y1 = py0_r; op.x2 = px1_r; op.y2 = py1_r;
        end
        2'd2: begin
          op.x1 = px1_r; op.y1 = py1_r; op.x2 = px0_r; op.y2 = py1_r;
        end
        default: begin
          op.x1 = px0_r; op.y1 = py1_r; op.x2 = px0_r; op.y2 = py0_r;
        end
      endcase
    end
  end

endmodule

>>> hdl/srri_core.sv
// ----------------------------------------------------------------------------
// srri_core
// Four-stage test of one segment against rectangle A: operands, differences,
// products, cross values, with the range compares behind the last.
// ----------------------------------------------------------------------------
module srri_core import srri_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  srri_op_t  op,
  input  logic      op_valid,
  output logic      op_ready,
  output srri_res_t res,
  output logic      res_valid,
  input  logic      res_ready
);

  typedef logic signed [DW-1:0] srri_d_t;
  typedef logic signed [MW-1:0] srri_m_t;
  typedef logic signed [XW-1:0] srri_x_t;
  typedef logic signed [CW-1:0] srri_c_t;

  function automatic srri_d_t dext(input srri_pt_t a);
    return {a[PW-1], a};
  endfunction

  function automatic srri_x_t xext(input srri_m_t a);
    return {a[MW-1], a};
  endfunction

  function automatic logic pt_inside(input srri_pt_t l, input srri_pt_t r, input srri_pt_t t,
                                     input srri_pt_t d, input srri_pt_t x, input srri_pt_t y);
    logic hz, wz, s0p, s0n, s1p, s1n, s2p, s2n, s3p, s3n;
    hz  = (d != t);
    wz  = (r != l);
    s0p = hz && (x < l);
    s0n = hz && (x > l);
    s1p = wz && (y > d);
    s1n = wz && (y < d);
    s2p = hz && (x > r);
    s2n = hz && (x < r);
    s3p = wz && (y < t);
    s3n = wz && (y > t);
    return !((s0p && s1n) || (s0n && s1p) || (s1p && s2n) || (s1n && s2p) ||
             (s2p && s3n) || (s2n && s3p) || (s3p && s0n) || (s3n && s0p));
  endfunction

  function automatic logic in_unit(input srri_x_t num, input srri_x_t den);
    srri_c_t dm;
    dm = {den[XW-1], den} - {num[XW-1], num};
    if (!den[XW-1]) return !num[XW-1] && !dm[CW-1];
    return (num[XW-1] || (num == '0)) && (dm[CW-1] || (dm == '0));
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  srri_op_t s1_r;

  srri_d_t rx_r, ry_r, h_r, w_r, dl_r, dr_r, dt_r, dd_r;
  logic    in2_r, first2_r, last2_r;

  srri_m_t prh_r, prw_r, tl_r, tr_r, tt_r, td_r, al_r, ar_r, bt_r, bd_r;
  logic    in3_r, first3_r, last3_r;

  srri_x_t den_r [4];
  srri_x_t tn_r  [4];
  srri_x_t un_r  [4];
  logic    in4_r, first4_r, last4_r;

  logic [3:0] crossed;

  assign rdy4     = !v4_r || res_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign op_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= op_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= op;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rx_r     <= dext(s1_r.x2) - dext(s1_r.x1);
      ry_r     <= dext(s1_r.y2) - dext(s1_r.y1);
      h_r      <= dext(s1_r.d) - dext(s1_r.t);
      w_r      <= dext(s1_r.r) - dext(s1_r.l);
      dl_r     <= dext(s1_r.l) - dext(s1_r.x1);
      dr_r     <= dext(s1_r.r) - dext(s1_r.x1);
      dt_r     <= dext(s1_r.t) - dext(s1_r.y1);
      dd_r     <= dext(s1_r.d) - dext(s1_r.y1);
      in2_r    <= pt_inside(s1_r.l, s1_r.r, s1_r.t, s1_r.d, s1_r.x1, s1_r.y1) ||
                  pt_inside(s1_r.l, s1_r.r, s1_r.t, s1_r.d, s1_r.x2, s1_r.y2);
      first2_r <= s1_r.first;
      last2_r  <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prh_r    <= rx_r * h_r;
      prw_r    <= ry_r * w_r;
      tl_r     <= dl_r * h_r;
      tr_r     <= dr_r * h_r;
      tt_r     <= dt_r * w_r;
      td_r     <= dd_r * w_r;
      al_r     <= dl_r * ry_r;
      ar_r     <= dr_r * ry_r;
      bt_r     <= dt_r * rx_r;
      bd_r     <= dd_r * rx_r;
      in3_r    <= in2_r;
      first3_r <= first2_r;
      last3_r  <= last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      den_r[0] <= xext(prh_r);
      tn_r[0]  <= xext(tl_r);
      un_r[0]  <= xext(al_r) - xext(bt_r);
      den_r[1] <= -xext(prw_r);
      tn_r[1]  <= -xext(td_r);
      un_r[1]  <= xext(al_r) - xext(bd_r);
      den_r[2] <= -xext(prh_r);
      tn_r[2]  <= -xext(tr_r);
      un_r[2]  <= xext(ar_r) - xext(bd_r);
      den_r[3] <= xext(prw_r);
      tn_r[3]  <= xext(tt_r);
      un_r[3]  <= xext(ar_r) - xext(bt_r);
      in4_r    <= in3_r;
      first4_r <= first3_r;
      last4_r  <= last3_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      crossed[i] = !((den_r[i] < PAR_THR) && (den_r[i] > -PAR_THR)) &&
                   in_unit(tn_r[i], den_r[i]) && in_unit(un_r[i], den_r[i]);
    end
  end

  assign res_valid = v4_r;
  assign res.hit   = in4_r || (|crossed);
  assign res.first = first4_r;
  assign res.last  = last4_r;

endmodule

>>> hdl/srri_collect.sv
// ----------------------------------------------------------------------------
// srri_collect
// Merges the edge ops of one request and holds the result for the sink.
// ----------------------------------------------------------------------------
module srri_collect import srri_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  srri_res_t res,
  input  logic      res_valid,
  output logic      res_ready,
  srri_out_if.source out_chan
);

  logic acc_r, out_valid_r, out_hit_r;
  logic take, merged;

  assign res_ready      = !out_valid_r || out_chan.ready;
  assign take           = res_valid && res_ready;
  assign merged         = (res.first ? 1'b0 : acc_r) || res.hit;
  assign out_chan.valid = out_valid_r;
  assign out_chan.hit   = out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && res.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (res.last) out_hit_r <= merged;
      else acc_r <= merged;
    end
  end

endmodule

>>> hdl/segment_rect_rect_intersect.sv
// ----------------------------------------------------------------------------
// segment_rect_rect_intersect
// Exact hit test of a segment or of rectangle B against rectangle A.
// ----------------------------------------------------------------------------
// A segment request becomes one op of the issue stage, a rectangle request
// four (one for each edge of B, all fed through the same test pipeline).
// Throughput is one segment every cycle while op_ready and the result sink
// do not stall; a new request is taken only as the last op of the one before
// issues. A result passes through the issue register, four pipeline registers
// (operands, differences, products, cross values, with the range compares
// behind the last) and the output register. The output register lets new
// requests enter while a result waits to be taken.
module segment_rect_rect_intersect import srri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srri_in_if.sink    in_chan,
  srri_out_if.source out_chan
);

  srri_op_t  op;
  logic      op_valid, op_ready;
  srri_res_t res;
  logic      res_valid, res_ready;

  srri_issue u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready)
  );

  srri_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  srri_collect u_collect (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_chan  (out_chan)
  );

endmodule

>>> sim/hit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_checker
// Watches the request and result channels of the hit tester, predicts the
// hit flag of every accepted request with exact wide arithmetic and compares
// it with the results in order.
// ----------------------------------------------------------------------------
module hit_checker import srri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srri_in_if.sink    in_mon,
  srri_out_if.sink   out_mon,
  output int         fail_count,
  output int         pending
);

  typedef logic signed [127:0] wide_t;

  logic expected_hits[$];

  function automatic int sgn(wide_t v);
    if (v < 0) return -1;
    return (v != 0) ? 1 : 0;
  endfunction

  function automatic wide_t xprod(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * by - ay * bx;
  endfunction

  function automatic bit pt_in_rect(wide_t cx[4], wide_t cy[4], wide_t px, wide_t py);
    int s[4];
    int j;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      s[i] = sgn(xprod(cx[j] - cx[i], cy[j] - cy[i], px - cx[i], py - cy[i]));
    end
    for (int i = 0; i < 4; i++)
      if (s[i] * s[(i + 1) % 4] < 0) return 0;
    return 1;
  endfunction

  function automatic bit unit_range(wide_t num, wide_t den, int ds);
    if (ds > 0) return num >= 0 && den - num >= 0;
    return num <= 0 && num - den >= 0;
  endfunction

  function automatic bit edges_cross(wide_t x1, wide_t y1, wide_t x2, wide_t y2,
                                     wide_t x3, wide_t y3, wide_t x4, wide_t y4);
    wide_t den, tn, un, mag;
    den = xprod(x2 - x1, y2 - y1, x4 - x3, y4 - y3);
    tn  = xprod(x3 - x1, y3 - y1, x4 - x3, y4 - y3);
    un  = xprod(x3 - x1, y3 - y1, x2 - x1, y2 - y1);
    mag = den < 0 ? -den : den;
    if (mag < wide_t'(PAR_VAL)) return 0;
    return unit_range(tn, den, sgn(den)) && unit_range(un, den, sgn(den));
  endfunction

  function automatic bit segment_hits(wide_t cx[4], wide_t cy[4],
                                      wide_t x1, wide_t y1, wide_t x2, wide_t y2);
    int j;
    if (pt_in_rect(cx, cy, x1, y1) || pt_in_rect(cx, cy, x2, y2)) return 1;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      if (edges_cross(x1, y1, x2, y2, cx[i], cy[i], cx[j], cy[j])) return 1;
    end
    return 0;
  endfunction

  function automatic wide_t raise_size(wide_t s);
    return (s < wide_t'(ONE_VAL)) ? wide_t'(CLAMP_VAL) : s;
  endfunction

  function automatic bit predict_hit(logic act, srri_coord_t ax, srri_coord_t ay,
                                     srri_size_t aw, srri_size_t ah, srri_coord_t fx,
                                     srri_coord_t fy, srri_coord_t gx, srri_coord_t gy);
    wide_t cx[4], cy[4], px[4], py[4];
    wide_t w, h, bw, bh;
    bit hit;
    int j;
    w = wide_t'({1'b0, aw});
    h = wide_t'({1'b0, ah});
    if (act == ACT_RECT) begin
      w = raise_size(w);
      h = raise_size(h);
    end
    cx[0] = 2 * wide_t'(ax) - w; cy[0] = 2 * wide_t'(ay) - h;
    cx[1] = 2 * wide_t'(ax) - w; cy[1] = 2 * wide_t'(ay) + h;
    cx[2] = 2 * wide_t'(ax) + w; cy[2] = 2 * wide_t'(ay) + h;
    cx[3] = 2 * wide_t'(ax) + w; cy[3] = 2 * wide_t'(ay) - h;
    if (act == ACT_SEG)
      return segment_hits(cx, cy, 2 * wide_t'(fx), 2 * wide_t'(fy),
                          2 * wide_t'(gx), 2 * wide_t'(gy));
    bw = raise_size(wide_t'(gx));
    bh = raise_size(wide_t'(gy));
    px[0] = 2 * wide_t'(fx) - bw; py[0] = 2 * wide_t'(fy) - bh;
    px[1] = 2 * wide_t'(fx) + bw; py[1] = 2 * wide_t'(fy) - bh;
    px[2] = 2 * wide_t'(fx) + bw; py[2] = 2 * wide_t'(fy) + bh;
    px[3] = 2 * wide_t'(fx) - bw; py[3] = 2 * wide_t'(fy) + bh;
    hit = 0;
    for (int i = 0; i < 4 && !hit; i++) begin
      j = (i + 1) % 4;
      hit = segment_hits(cx, cy, px[i], py[i], px[j], py[j]);
    end
    return hit;
  endfunction

  assign pending = expected_hits.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic exp_hit;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_hits.push_back(predict_hit(in_mon.action, in_mon.a_center_x,
          in_mon.a_center_y, in_mon.a_width, in_mon.a_height, in_mon.first_x,
          in_mon.first_y, in_mon.second_x, in_mon.second_y));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hits.size() == 0) begin
          $error("hit: unexpected result %0b", out_mon.hit);
          fail_count <= fail_count + 1;
        end else begin
          exp_hit = expected_hits.pop_front();
          if (out_mon.hit !== exp_hit) begin
            $error("hit: expected %0b actual %0b", exp_hit, out_mon.hit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_segment_rect_rect_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_rect_rect_intersect
// Drives directed and random segment and rectangle requests with random gaps
// and result stalls, including a long result hold-off and a full drain, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_segment_rect_rect_intersect;
  import srri_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   hold_results = 1'b0;
  bit   stim_done = 1'b0;

  srri_in_if  in_chan();
  srri_out_if out_chan();

  segment_rect_rect_intersect u_dut (.clk(clk), .rst_n(rst_n), .in_chan(in_chan),
                                     .out_chan(out_chan));

  hit_checker u_checker (.clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
                         .fail_count(fail_count), .pending(pending));

  always #6 clk = ~clk;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.action = ACT_SEG;
    in_chan.a_center_x = '0;
    in_chan.a_center_y = '0;
    in_chan.a_width = '0;
    in_chan.a_height = '0;
    in_chan.first_x = '0;
    in_chan.first_y = '0;
    in_chan.second_x = '0;
    in_chan.second_y = '0;
    out_chan.ready = 1'b0;
  end

  function automatic srri_coord_t rand_coord(int mode);
    case (mode)
      0: return srri_coord_t'($urandom);
      1: return srri_coord_t'($signed($urandom_range(0, 8192)) - 4096);
      default: return srri_coord_t'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic srri_size_t rand_size(int mode);
    case (mode)
      0: return srri_size_t'($urandom);
      1: return srri_size_t'($urandom_range(0, 4096));
      default: return srri_size_t'($urandom_range(0, 600));
    endcase
  endfunction

  task automatic send_request(logic act, srri_coord_t ax, srri_coord_t ay, srri_size_t aw,
                              srri_size_t ah, srri_coord_t fx, srri_coord_t fy,
                              srri_coord_t gx, srri_coord_t gy, int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= act;
    in_chan.a_center_x <= ax;
    in_chan.a_center_y <= ay;
    in_chan.a_width <= aw;
    in_chan.a_height <= ah;
    in_chan.first_x <= fx;
    in_chan.first_y <= fy;
    in_chan.second_x <= gx;
    in_chan.second_y <= gy;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_random(int gap);
    int mode;
    logic act;
    srri_coord_t ax, ay;
    srri_size_t aw, ah;
    mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
    act = logic'($urandom_range(0, 1));
    ax = rand_coord(mode);
    ay = rand_coord(mode);
    aw = rand_size(mode);
    ah = rand_size(mode);
    if (act == ACT_RECT)
      send_request(act, ax, ay, aw, ah, rand_coord(mode), rand_coord(mode),
                   srri_coord_t'(srri_coord_t'(rand_size(mode)) - 40),
                   srri_coord_t'(srri_coord_t'(rand_size(mode)) - 40),
                   gap);
    else
      send_request(act, ax, ay, aw, ah, rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), gap);
  endtask

  initial begin
    localparam srri_coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam srri_coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam srri_size_t SMAX = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // extremes, degenerate A, parallel and collinear edges, clamping, containment
    send_request(ACT_SEG, CMAX, CMIN, SMAX, SMAX, CMIN, CMAX, CMAX, CMIN, 0);
    send_request(ACT_SEG, CMIN, CMAX, SMAX, 0, CMAX, CMAX, CMIN, CMIN, 0);
    send_request(ACT_SEG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SEG, 0, 0, 0, 0, -256, -256, 256, 256, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, -1024, 256, 1024, 256, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, -1024, 257, 1024, 257, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, 512, 256, 1024, 256, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, 256, -1024, 256, 1024, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, -100, -100, 100, 100, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, -1024, -1000, 1000, 1024, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, 300, 300, 400, 400, 0);
    send_request(ACT_SEG, 0, 0, 512, 512, 0, 0, 1, 0, 0);
    send_request(ACT_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_RECT, 0, 0, 255, 255, 1, 1, 255, 255, 0);
    send_request(ACT_RECT, 0, 0, 256, 256, 300, 0, 256, 256, 0);
    send_request(ACT_RECT, 0, 0, 256, 256, 0, 0, 4096, 4096, 0);
    send_request(ACT_RECT, 0, 0, 256, 256, 5000, 5000, -5, CMIN, 0);
    send_request(ACT_RECT, CMAX, CMAX, SMAX, SMAX, CMIN, CMIN, CMAX, CMAX, 0);
    send_request(ACT_RECT, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, CMIN, CMIN, 0);
    send_request(ACT_RECT, 0, 0, 512, 512, 512, 0, 512, 512, 0);
    // long result hold-off while requests keep coming
    hold_results = 1'b1;
    for (int i = 0; i < 12; i++) send_random(0);
    hold_results = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // drain everything before going on
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    end
    in_chan.valid <= 1'b0;
    @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
        out_chan.ready <= 1'b1;
        wait (!hold_results);
      end else if ($urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b1;
      end else begin
        hold = $urandom_range(0, 17);
        if (hold == 0) begin
          out_chan.ready <= 1'b1;
        end else begin
          out_chan.ready <= 1'b0;
          repeat (hold - 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("segment_rect_rect_intersect verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("segment_rect_rect_intersect verification clean");
    else
      $display("segment_rect_rect_intersect verification failed");
    $finish;
  end

endmodule
